@@ src/b58_pkg.sv @@
// Shared types, constants and the character map for the base58 encoder.
// No dependencies; imported by b58_cell and base58_encoder.
`default_nettype none

package b58_pkg;

    localparam int MAX_BYTES_DEF  = 32;
    localparam int MAX_DIGITS_DEF = 44;

    localparam int DIGIT_W = 6;
    localparam int CARRY_W = 8;
    localparam int VAL_W   = DIGIT_W + 8;

    localparam int RADIX = 58;
    // floor(v * 1130 / 2^16) == floor(v / 58) for every v below 58 * 256
    localparam int RECIP       = 1130;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = VAL_W + 11;

    localparam logic [6:0] CHAR_ONE = 7'h31;

    // first character in the top byte
    localparam logic [8*RADIX-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic shift;    // move every digit one cell up, zero into cell 0
        logic clear;    // zero every digit
    } t_cell_ctl;

    function automatic logic [6:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] idx;
        idx = (d < DIGIT_W'(RADIX)) ? d : '0;
        return ALPHABET[8*(RADIX-1-int'(idx)) +: 7];
    endfunction

endpackage

`default_nettype wire

@@ src/base58_encoder.sv @@
// Base58 encoder top: byte intake, a chain of MAX_DIGITS digit cells and the
// character output sequencer. Uses b58_pkg and b58_cell.
// Each byte's carry travels one cell per cycle through the chain.
// After the last byte: a setup state, an align state that shifts the digits up, then
// one character per cycle while m_axis_tready is high.
// Synchronous active-low reset clears digits, state and the intake counters at once.
`default_nettype none

module base58_encoder #(
    parameter int MAX_BYTES  = b58_pkg::MAX_BYTES_DEF,
    parameter int MAX_DIGITS = b58_pkg::MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic       m_axis_tlast,   // last_char
    output logic       m_axis_tuser    // [0] overflow
);
    import b58_pkg::*;

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int BW = $clog2(MAX_BYTES + 1);
    localparam int TW = ((CW > BW) ? CW : BW) + 1;
    localparam logic [CW-1:0] DIGITS_N = CW'(MAX_DIGITS);
    localparam logic [BW-1:0] BYTES_N  = BW'(MAX_BYTES);

    typedef enum logic [2:0] {S_IDLE, S_FOLD, S_PREP, S_ALIGN, S_EMIT} t_state;

    t_state             r_state;
    logic               r_launch_vld;
    logic [CARRY_W-1:0] r_launch_carry;
    logic [CW-1:0]      r_pos;
    logic [CW-1:0]      r_count;
    logic [BW-1:0]      r_lz;
    logic               r_in_lz;
    logic [BW-1:0]      r_bytes;
    logic               r_exceeded;
    logic               r_last_pend;
    logic [CW-1:0]      r_left;
    logic [BW-1:0]      r_ones;
    logic [CW-1:0]      r_align;
    logic               r_ovf;
    logic               r_m_valid;
    logic [6:0]         r_m_char;
    logic               r_m_last;
    logic               r_m_user;

    logic [MAX_DIGITS:0]  w_vld;
    logic [CARRY_W-1:0]   w_carry [MAX_DIGITS+1];
    logic [DIGIT_W-1:0]   w_digit [MAX_DIGITS+1];
    logic [MAX_DIGITS-1:0] w_grow;
    t_cell_ctl            w_ctl;

    logic          w_accept;
    logic          w_out_free;
    logic          w_drop;
    logic [CW-1:0] w_ndig;
    logic [TW-1:0] w_total;
    logic          w_trunc;
    logic [CW-1:0] w_n;
    logic          w_emit;
    logic          w_emit_one;
    logic          w_emit_last;

    assign w_vld[0]   = r_launch_vld;
    assign w_carry[0] = r_launch_carry;
    assign w_digit[0] = '0;

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        b58_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_vld        (w_vld[g]),
            .i_carry      (w_carry[g]),
            .i_prev_digit (w_digit[g]),
            .o_vld        (w_vld[g+1]),
            .o_carry      (w_carry[g+1]),
            .o_digit      (w_digit[g+1]),
            .o_grow       (w_grow[g])
        );
    end

    always_comb begin
        w_accept    = s_axis_tvalid && s_axis_tready;
        w_out_free  = !r_m_valid || m_axis_tready;
        w_drop      = (r_bytes >= BYTES_N);
        w_ndig      = r_in_lz ? '0 : r_count;
        w_total     = TW'(r_lz) + TW'(w_ndig);
        w_trunc     = (w_total > TW'(MAX_DIGITS));
        w_n         = w_trunc ? DIGITS_N : w_total[CW-1:0];
        w_emit      = (r_state == S_EMIT) && w_out_free;
        w_emit_one  = (r_ones != '0);
        w_emit_last = (r_left == CW'(1));
        w_ctl.shift = ((r_state == S_ALIGN) && (r_align != '0)) || (w_emit && !w_emit_one);
        w_ctl.clear = w_emit && w_emit_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_launch_vld <= 1'b0;
            r_count      <= CW'(1);
            r_lz         <= '0;
            r_in_lz      <= 1'b1;
            r_bytes      <= '0;
            r_exceeded   <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_launch_vld <= 1'b0;

            if (w_emit) begin
                r_m_valid <= 1'b1;
                r_m_char  <= w_emit_one ? CHAR_ONE : b58_char(w_digit[MAX_DIGITS]);
                r_m_last  <= w_emit_last;
                r_m_user  <= r_ovf;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_drop) begin
                            r_exceeded <= 1'b1;
                            if (s_axis_tlast) begin
                                r_state <= S_PREP;
                            end
                        end else begin
                            r_bytes <= r_bytes + BW'(1);
                            if (r_in_lz && (s_axis_tdata == 8'h00)) begin
                                r_lz <= r_lz + BW'(1);
                            end else begin
                                r_in_lz <= 1'b0;
                            end
                            r_launch_vld   <= 1'b1;
                            r_launch_carry <= s_axis_tdata;
                            r_pos          <= '0;
                            r_last_pend    <= s_axis_tlast;
                            r_state        <= S_FOLD;
                        end
                    end
                end
                S_FOLD: begin
                    r_pos <= r_pos + CW'(1);
                    // a nonzero carry reaching an unused cell extends the number
                    if ((|w_grow) && (r_pos >= r_count)) begin
                        r_count <= r_pos + CW'(1);
                    end
                    if (w_vld[MAX_DIGITS]) begin
                        if (w_carry[MAX_DIGITS] != '0) begin
                            r_exceeded <= 1'b1;
                        end
                        r_state <= r_last_pend ? S_PREP : S_IDLE;
                    end
                end
                S_PREP: begin
                    r_left  <= w_n;
                    r_ones  <= r_lz;
                    r_align <= DIGITS_N - w_ndig;
                    r_ovf   <= r_exceeded || w_trunc;
                    r_state <= S_ALIGN;
                end
                S_ALIGN: begin
                    if (r_align == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_align <= r_align - CW'(1);
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_left <= r_left - CW'(1);
                        if (w_emit_one) begin
                            r_ones <= r_ones - BW'(1);
                        end
                        if (w_emit_last) begin
                            r_count    <= CW'(1);
                            r_lz       <= '0;
                            r_in_lz    <= 1'b1;
                            r_bytes    <= '0;
                            r_exceeded <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_char};
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_user;

endmodule

`default_nettype wire

@@ src/b58_cell.sv @@
// One radix-58 digit of the running number: digit*256 + carry, split into
// a new digit and a carry for the next cell. Uses b58_pkg.
`default_nettype none

module b58_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  b58_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_vld,
    input  logic [b58_pkg::CARRY_W-1:0] i_carry,
    input  logic [b58_pkg::DIGIT_W-1:0] i_prev_digit,
    output logic                      o_vld,
    output logic [b58_pkg::CARRY_W-1:0] o_carry,
    output logic [b58_pkg::DIGIT_W-1:0] o_digit,
    output logic                      o_grow
);
    import b58_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic               r_vld;
    logic [CARRY_W-1:0] r_carry;

    logic [VAL_W-1:0]   w_val;
    logic [PROD_W-1:0]  w_prod;
    logic [CARRY_W-1:0] w_quot;
    logic [VAL_W-1:0]   w_qm;
    logic [VAL_W-1:0]   w_rem;

    assign w_val  = {r_digit, 8'h00} + VAL_W'(i_carry);
    assign w_prod = PROD_W'(w_val) * PROD_W'(RECIP);
    assign w_quot = w_prod[RECIP_SHIFT +: CARRY_W];
    assign w_qm   = VAL_W'(w_quot) * VAL_W'(RADIX);
    assign w_rem  = w_val - w_qm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_vld <= i_vld && !i_ctl.clear;
            if (i_ctl.clear) begin
                r_digit <= '0;
            end else if (i_ctl.shift) begin
                r_digit <= i_prev_digit;
            end else if (i_vld) begin
                r_digit <= w_rem[DIGIT_W-1:0];
            end
        end
        r_carry <= w_quot;
    end

    assign o_vld   = r_vld;
    assign o_carry = r_carry;
    assign o_digit = r_digit;
    assign o_grow  = i_vld && (i_carry != '0);

endmodule

`default_nettype wire

@@ src/b58_checker.sv @@
// Port-level checks for base58_encoder, attached by the bind below.
// Sees only the top-level ports; no package use.
`default_nettype none

module b58_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // every word has bit 7 clear and a code from '1' to 'z', the span of the base58 alphabet
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7] == 1'b0 && m_axis_tdata[6:0] >= 7'd49
                           && m_axis_tdata[6:0] <= 7'd122))
        else $error("character out of range");

    // no new bytes taken while a message is still being written out
    a_no_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input ready during character output");

    // a finished message leaves a gap before any further character
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("character right after final character");

    // overflow flag is constant across one message
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1 m_axis_tvalid
        |-> (m_axis_tuser == $past(m_axis_tuser)))
        else $error("overflow flag changed within a message");

endmodule

bind base58_encoder b58_checker u_b58_checker (.*);

`default_nettype wire
